// ===== sv/charlieplex_ring_pattern_driver_defines.svh =====
// assertion macros for the ring pattern driver checker
`ifndef CHARLIEPLEX_RING_PATTERN_DRIVER_DEFINES_SVH
`define CHARLIEPLEX_RING_PATTERN_DRIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CRPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crpd assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CRPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crpd assertion failed");

`endif

// ===== sv/crpd_pkg.sv =====
package crpd_pkg;

  localparam int RING_SIZE     = 90;
  localparam int LINE_COUNT    = 10;
  localparam int PATTERN_COUNT = 3;

  localparam int LED_W    = 7;
  localparam int CMD_W    = 2;
  localparam int SAMPLE_W = 12;
  localparam int RAND_W   = 16;
  localparam int STEP_W   = 7;
  localparam int OFFSET_W = 13;
  localparam int CFG_W    = 13;

  localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(1);
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(4140);
  localparam logic [LED_W-1:0]    CENTER_RESET = LED_W'(45);

  // reciprocal for the constant modulo by the ring size
  localparam int MOD_IN_W  = 16;
  localparam int MOD_SHIFT = 22;
  localparam int RECIP_W   = 22;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << MOD_SHIFT) / RING_SIZE);

  typedef enum logic [CMD_W-1:0] {
    CMD_ROTATE = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_BUTTON = 2'd2,
    CMD_HOLD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PAT_WAVE    = 2'd0,
    PAT_SPARKLE = 2'd1,
    PAT_STEP    = 2'd2
  } pattern_t;

  typedef enum logic {
    CFG_ROTATION_STEP = 1'b0,
    CFG_SAMPLE_OFFSET = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [LED_W-1:0] current_led;
    logic [LED_W-1:0] rotation_center;
    pattern_t         pattern;
    logic             button_down;
    logic             hold_armed;
    logic             asleep;
  } crpd_state_t;

endpackage

// ===== sv/crpd_ring_mod.sv =====
module crpd_ring_mod
  import crpd_pkg::*;
(
  input  logic [MOD_IN_W-1:0] value_in,
  output logic [LED_W-1:0]    remainder
);

  logic [MOD_IN_W+RECIP_W-1:0] prod;
  logic [MOD_IN_W-1:0]         quot;
  logic [MOD_IN_W:0]           rem_est;

  // quotient estimate is exact or one low
  always_comb begin
    prod    = (MOD_IN_W+RECIP_W)'(value_in) * (MOD_IN_W+RECIP_W)'(RECIP);
    quot    = prod[MOD_IN_W+RECIP_W-1:MOD_SHIFT];
    rem_est = {1'b0, value_in} - (MOD_IN_W+1)'(quot * (MOD_IN_W+1)'(RING_SIZE));
    if (rem_est >= (MOD_IN_W+1)'(RING_SIZE)) begin
      remainder = LED_W'(rem_est - (MOD_IN_W+1)'(RING_SIZE));
    end else begin
      remainder = LED_W'(rem_est);
    end
  end

endmodule

// ===== sv/crpd_event.sv =====
module crpd_event
  import crpd_pkg::*;
(
  input  crpd_state_t          state,
  input  cmd_t                 cmd,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic [RAND_W-1:0]    random_value,
  input  logic [STEP_W-1:0]    rotation_step,
  input  logic [OFFSET_W-1:0]  sample_offset,
  output crpd_state_t          state_nxt
);

  logic [MOD_IN_W-1:0] mod_operand;
  logic [LED_W-1:0]    mod_result;

  crpd_ring_mod u_ring_mod (
    .value_in  (mod_operand),
    .remainder (mod_result)
  );

  // one shared modulo unit: rotate sum or sample source
  always_comb begin
    if (cmd == CMD_ROTATE) begin
      mod_operand = MOD_IN_W'(state.rotation_center) + MOD_IN_W'(rotation_step);
    end else if (state.pattern == PAT_WAVE) begin
      mod_operand = MOD_IN_W'(sample_offset) + MOD_IN_W'(state.rotation_center)
                  + MOD_IN_W'(sample);
    end else begin
      mod_operand = MOD_IN_W'(random_value);
    end
  end

  always_comb begin
    state_nxt = state;
    unique case (cmd)
      CMD_ROTATE: begin
        if (!state.asleep) begin
          state_nxt.rotation_center = mod_result;
        end
      end
      CMD_SAMPLE: begin
        if (!state.asleep) begin
          case (state.pattern)
            PAT_WAVE, PAT_SPARKLE: state_nxt.current_led = mod_result;
            PAT_STEP: begin
              if (state.current_led == LED_W'(RING_SIZE - 1)) begin
                state_nxt.current_led = '0;
              end else begin
                state_nxt.current_led = state.current_led + LED_W'(1);
              end
            end
            default: state_nxt.current_led = state.current_led;
          endcase
        end
      end
      CMD_BUTTON: begin
        state_nxt.button_down = !state.button_down;
        if (!state.button_down) begin
          state_nxt.hold_armed = 1'b1;
          if (!state.asleep) begin
            priority if (state.pattern == PAT_STEP) begin
              state_nxt.pattern = PAT_WAVE;
            end else begin
              state_nxt.pattern = pattern_t'(state.pattern + 2'd1);
            end
          end
        end else begin
          state_nxt.hold_armed = 1'b0;
        end
      end
      CMD_HOLD: begin
        if (state.hold_armed) begin
          state_nxt.asleep     = !state.asleep;
          state_nxt.hold_armed = 1'b0;
        end
      end
    endcase
  end

endmodule

// ===== sv/crpd_line_dec.sv =====
module crpd_line_dec
  import crpd_pkg::*;
(
  input  logic [LED_W-1:0]      led,
  input  logic                  asleep,
  output logic [LINE_COUNT-1:0] line_enable,
  output logic [LINE_COUNT-1:0] line_high
);

  localparam int M = LINE_COUNT - 1;

  logic [LED_W-1:0] col;
  logic [LED_W-1:0] mrem;
  logic [LED_W-1:0] row;

  // led to column and remainder, one compare per ring position
  always_comb begin
    int c;
    int mm;
    c    = 0;
    mm   = 0;
    col  = '0;
    mrem = '0;
    for (int i = 0; i < RING_SIZE; i++) begin
      if (led == LED_W'(i)) begin
        col  = LED_W'(c);
        mrem = LED_W'(mm);
      end
      if (mm == M - 1) begin
        mm = 0;
        c  = c + 1;
      end else begin
        mm = mm + 1;
      end
    end
  end

  always_comb begin
    row = LED_W'(M) - mrem;
    if (col <= LED_W'(M) && (LED_W'(M) - col) <= mrem) begin
      row = row - LED_W'(1);
    end
  end

  always_comb begin
    for (int j = 0; j < LINE_COUNT; j++) begin
      line_high[j]   = !asleep && (col == LED_W'(j));
      line_enable[j] = !asleep && ((col == LED_W'(j)) || (row == LED_W'(j)));
    end
  end

endmodule

// ===== sv/charlieplex_ring_pattern_driver.sv =====
// an input transfer goes through the input register, then the result register, before the result is valid
// throughput: one event per cycle while no result is held; all state updates in a single combinational pass
// the only back pressure is a held result: in_stall follows out_stall when both stages are full
// reset (rst_n low, synchronous): stages empty, led 0, center 45, waveform pattern,
//   button released, hold disarmed, awake, rotation_step 1, sample_offset 4140
module charlieplex_ring_pattern_driver
  import crpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write_en,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic [RAND_W-1:0]     in_random_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LINE_COUNT-1:0] out_line_enable,
  output logic [LINE_COUNT-1:0] out_line_high,
  output logic [LED_W-1:0]      out_lit_index,
  output logic [1:0]            out_pattern_now,
  output logic                  out_asleep_now
);

  logic [STEP_W-1:0]   rotation_step_r;
  logic [OFFSET_W-1:0] sample_offset_r;

  logic                in_valid_r;
  cmd_t                in_cmd_r;
  logic [SAMPLE_W-1:0] in_sample_r;
  logic [RAND_W-1:0]   in_random_value_r;

  logic                out_valid_r;
  crpd_state_t         state_r;
  crpd_state_t         state_nxt;

  logic                advance;
  logic                in_xfer;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_step_r <= STEP_RESET;
      sample_offset_r <= OFFSET_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ROTATION_STEP: rotation_step_r <= cfg_data[STEP_W-1:0];
        CFG_SAMPLE_OFFSET: sample_offset_r <= cfg_data[OFFSET_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_cmd_r          <= cmd_t'(in_cmd);
      in_sample_r       <= in_sample;
      in_random_value_r <= in_random_value;
    end
  end

  crpd_event u_event (
    .state         (state_r),
    .cmd           (in_cmd_r),
    .sample        (in_sample_r),
    .random_value  (in_random_value_r),
    .rotation_step (rotation_step_r),
    .sample_offset (sample_offset_r),
    .state_nxt     (state_nxt)
  );

  // state doubles as the result register: it only moves when the result slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r             <= 1'b0;
      state_r.current_led     <= '0;
      state_r.rotation_center <= CENTER_RESET;
      state_r.pattern         <= PAT_WAVE;
      state_r.button_down     <= 1'b0;
      state_r.hold_armed      <= 1'b0;
      state_r.asleep          <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  crpd_line_dec u_line_dec (
    .led         (state_r.current_led),
    .asleep      (state_r.asleep),
    .line_enable (out_line_enable),
    .line_high   (out_line_high)
  );

  assign out_valid       = out_valid_r;
  assign out_lit_index   = state_r.current_led;
  assign out_pattern_now = state_r.pattern;
  assign out_asleep_now  = state_r.asleep;

endmodule

// ===== sv/crpd_checker.sv =====
`include "charlieplex_ring_pattern_driver_defines.svh"

module crpd_checker
  import crpd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [LINE_COUNT-1:0] out_line_enable,
  input logic [LINE_COUNT-1:0] out_line_high,
  input logic [LED_W-1:0]      out_lit_index,
  input logic                  out_asleep_now
);

  logic lines_blank;
  logic lines_pair;

  assign lines_blank = (out_line_enable == '0) && (out_line_high == '0);
  assign lines_pair  = $onehot(out_line_high) && ($countones(out_line_enable) == 2)
                     && ((out_line_high & ~out_line_enable) == '0);

  // sleep blanks every line
  `CRPD_ASSERT_NOW(a_sleep_blank, out_valid && out_asleep_now, lines_blank)

  // awake: one line high, one other line low, nothing else driven
  `CRPD_ASSERT_NOW(a_awake_two_lines, out_valid && !out_asleep_now, lines_pair)

  // input only backs up behind a held result
  `CRPD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // a held result keeps its led
  `CRPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_lit_index) && $stable(out_line_enable))

endmodule

bind charlieplex_ring_pattern_driver crpd_checker u_crpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_line_enable (out_line_enable),
  .out_line_high   (out_line_high),
  .out_lit_index   (out_lit_index),
  .out_asleep_now  (out_asleep_now)
);

// ===== tb/tb.sv =====
module tb;
  import crpd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 190;

  typedef struct {
    cmd_t                cmd;
    logic [SAMPLE_W-1:0] sample;
    logic [RAND_W-1:0]   random_value;
  } ring_event_t;

  typedef struct packed {
    logic [LINE_COUNT-1:0] line_enable;
    logic [LINE_COUNT-1:0] line_high;
    logic [LED_W-1:0]      lit_index;
    logic [1:0]            pattern_now;
    logic                  asleep_now;
  } ring_view_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_write_en = 1'b0;
  logic                  cfg_index = CFG_ROTATION_STEP;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd = '0;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic [RAND_W-1:0]     in_random_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LINE_COUNT-1:0] out_line_enable;
  logic [LINE_COUNT-1:0] out_line_high;
  logic [LED_W-1:0]      out_lit_index;
  logic [1:0]            out_pattern_now;
  logic                  out_asleep_now;

  // predicted block state and register copies
  int       led_now;
  int       center;
  pattern_t pat;
  logic     btn_down;
  logic     armed;
  logic     sleeping;
  int       step_cfg;
  int       offset_cfg;

  ring_event_t queued_events[$];
  ring_view_t  due_views[$];
  ring_event_t seen_event;
  ring_event_t next_event;
  ring_view_t  got_view;
  ring_view_t  want_view;

  logic in_taken = 1'b0;
  int   idle_cycles = 0;
  int   errors = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   stall_span = 0;

  always #6 clk = ~clk;

  charlieplex_ring_pattern_driver dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_sample       (in_sample),
    .in_random_value (in_random_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_enable (out_line_enable),
    .out_line_high   (out_line_high),
    .out_lit_index   (out_lit_index),
    .out_pattern_now (out_pattern_now),
    .out_asleep_now  (out_asleep_now)
  );

  function automatic ring_view_t next_ring_view(ring_event_t ev);
    ring_view_t v;
    int col;
    int m;
    int row;
    case (ev.cmd)
      CMD_ROTATE: begin
        if (!sleeping) center = (center + step_cfg) % RING_SIZE;
      end
      CMD_SAMPLE: begin
        if (!sleeping) begin
          case (pat)
            PAT_WAVE:    led_now = (offset_cfg + center + int'(ev.sample)) % RING_SIZE;
            PAT_SPARKLE: led_now = int'(ev.random_value) % RING_SIZE;
            PAT_STEP:    led_now = (led_now + 1) % RING_SIZE;
            default:     led_now = led_now;
          endcase
        end
      end
      CMD_BUTTON: begin
        btn_down = !btn_down;
        armed = btn_down;
        if (btn_down && !sleeping) pat = pattern_t'((int'(pat) + 1) % PATTERN_COUNT);
      end
      default: begin
        if (armed) begin
          sleeping = !sleeping;
          armed = 1'b0;
        end
      end
    endcase
    v = '0;
    if (!sleeping) begin
      col = led_now / (LINE_COUNT - 1);
      m = led_now % (LINE_COUNT - 1);
      row = LINE_COUNT - 1 - m;
      if (col <= LINE_COUNT - 1 && LINE_COUNT - 1 - col <= m) row--;
      if (col < LINE_COUNT) begin
        v.line_enable[col] = 1'b1;
        v.line_high[col] = 1'b1;
      end
      if (row < LINE_COUNT) v.line_enable[row] = 1'b1;
    end
    v.lit_index = LED_W'(led_now);
    v.pattern_now = pat;
    v.asleep_now = sleeping;
    return v;
  endfunction

  task automatic check_field(string name, logic [LINE_COUNT-1:0] want,
                             logic [LINE_COUNT-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // result monitor, prediction on input transfer, watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got_view = '{out_line_enable, out_line_high, out_lit_index, out_pattern_now,
                     out_asleep_now};
        if (due_views.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, actual %h", $time, got_view);
        end else begin
          want_view = due_views.pop_front();
          check_field("line_enable", want_view.line_enable, got_view.line_enable);
          check_field("line_high", want_view.line_high, got_view.line_high);
          check_field("lit_index", LINE_COUNT'(want_view.lit_index),
                      LINE_COUNT'(got_view.lit_index));
          check_field("pattern_now", LINE_COUNT'(want_view.pattern_now),
                      LINE_COUNT'(got_view.pattern_now));
          check_field("asleep_now", LINE_COUNT'(want_view.asleep_now),
                      LINE_COUNT'(got_view.asleep_now));
        end
      end
      if (in_valid && !in_stall) begin
        seen_event.cmd = cmd_t'(in_cmd);
        seen_event.sample = in_sample;
        seen_event.random_value = in_random_value;
        due_views.push_back(next_ring_view(seen_event));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // event sender, bursts with gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled transfer stays put
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (queued_events.size() != 0) begin
      next_event = queued_events.pop_front();
      in_valid <= 1'b1;
      in_cmd <= next_event.cmd;
      in_sample <= next_event.sample;
      in_random_value <= next_event.random_value;
      if (burst_left <= 1) begin
        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver stall pattern
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(8, 120);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  task automatic push_event(cmd_t cmd, int sample, int random_value);
    ring_event_t ev;
    ev.cmd = cmd;
    ev.sample = SAMPLE_W'(sample);
    ev.random_value = RAND_W'(random_value);
    queued_events.push_back(ev);
  endtask

  task automatic push_random_events(int count);
    int pick;
    cmd_t cmd;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = CMD_SAMPLE;
      else if (pick < 65) cmd = CMD_ROTATE;
      else if (pick < 87) cmd = CMD_BUTTON;
      else cmd = CMD_HOLD;
      push_event(cmd, $urandom_range(0, 4095), $urandom_range(0, 65535));
    end
  endtask

  task automatic write_reg(cfg_index_t idx, int value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    if (idx == CFG_ROTATION_STEP) step_cfg = value % 128;
    else offset_cfg = value % 8192;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // wait until every expected result has come back
  task automatic settle();
    while (queued_events.size() != 0 || in_valid || due_views.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int step_val;
    int offset_val;
    led_now = 0;
    center = int'(CENTER_RESET);
    pat = PAT_WAVE;
    btn_down = 1'b0;
    armed = 1'b0;
    sleeping = 1'b0;
    step_cfg = int'(STEP_RESET);
    offset_cfg = int'(OFFSET_RESET);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pass on reset register values
    push_event(CMD_HOLD, 4095, 65535);
    push_event(CMD_SAMPLE, 0, 0);
    push_event(CMD_SAMPLE, 4095, 65535);
    push_event(CMD_ROTATE, 0, 0);
    push_event(CMD_SAMPLE, 4095, 0);
    push_event(CMD_BUTTON, 4095, 65535);
    push_event(CMD_BUTTON, 0, 0);
    push_event(CMD_SAMPLE, 0, 65535);
    push_event(CMD_SAMPLE, 4095, 0);
    push_event(CMD_SAMPLE, 0, 89);
    push_event(CMD_BUTTON, 0, 0);
    push_event(CMD_SAMPLE, 0, 0);
    push_event(CMD_SAMPLE, 0, 0);
    push_event(CMD_HOLD, 0, 0);
    push_event(CMD_SAMPLE, 4095, 65535);
    push_event(CMD_ROTATE, 0, 0);
    push_event(CMD_HOLD, 0, 0);
    push_event(CMD_BUTTON, 0, 0);
    push_event(CMD_BUTTON, 0, 0);
    push_event(CMD_HOLD, 0, 0);
    push_event(CMD_SAMPLE, 0, 0);
    push_event(CMD_BUTTON, 0, 0);
    push_event(CMD_BUTTON, 0, 0);
    push_event(CMD_SAMPLE, 4095, 65535);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          step_val = 0;
          offset_val = 0;
        end
        1: begin
          step_val = RING_SIZE - 1;
          offset_val = 8191;
        end
        default: begin
          step_val = $urandom_range(0, RING_SIZE - 1);
          offset_val = $urandom_range(0, 8191);
        end
      endcase
      write_reg(CFG_ROTATION_STEP, step_val);
      write_reg(CFG_SAMPLE_OFFSET, offset_val);
      push_random_events(PHASE_ITEMS);
      settle();
    end

    repeat (6) @(posedge clk);
    if (errors == 0 && due_views.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
